### sv/rrtp_pkg.sv
// Shared types and constants for the round-robin thread picker.
`timescale 1ns / 1ps

package rrtp_pkg;

  // Table size and derived widths.
  localparam int MAX_THREADS    = 16;
  localparam int THREAD_ID_BITS = 8;
  localparam int SLOT_BITS      = $clog2(MAX_THREADS);
  localparam int LEN_BITS       = $clog2(MAX_THREADS + 1);

  // Request codes carried in the input word.
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_SET    = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_HIT,
    CMD_MISS
  } cmd_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // One request word.
  typedef struct packed {
    req_e                      req_type;
    logic [THREAD_ID_BITS-1:0] thread_id;
    logic [SLOT_BITS-1:0]      slot_index;
    logic                      runnable;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic                      ok;
    logic [SLOT_BITS-1:0]      slot;
    logic [THREAD_ID_BITS-1:0] chosen_thread;
    logic                      switched;
  } out_word_t;

  // Scan status reported by the datapath.
  typedef struct packed {
    logic scan_end;
    logic hit;
  } scan_status_t;

endpackage

### sv/rrtp_datapath.sv
// Slot table, scan cursor, scheduler state and result register.
`timescale 1ns / 1ps

module rrtp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rrtp_pkg::cmd_e        cmd_i,
  input  rrtp_pkg::in_word_t    in_i,
  output rrtp_pkg::scan_status_t status_o,
  output logic                  done_o,
  output rrtp_pkg::out_word_t   out_o
);
  import rrtp_pkg::*;

  in_word_t                  req_q, req_d;
  logic [SLOT_BITS-1:0]      cursor_q, cursor_d;
  logic [LEN_BITS-1:0]       count_q, count_d;
  logic [LEN_BITS-1:0]       len_q, len_d;
  logic [SLOT_BITS-1:0]      nptr_q, nptr_d;
  logic [SLOT_BITS-1:0]      rslot_q, rslot_d;
  logic                      rvalid_q, rvalid_d;
  logic [MAX_THREADS-1:0]    used_q, used_d;
  logic [MAX_THREADS-1:0]    ready_q, ready_d;
  logic [THREAD_ID_BITS-1:0] thread_q [MAX_THREADS];
  out_word_t                 out_q, out_d;
  logic                      done_q, done_d;

  logic [LEN_BITS-1:0]  cursor_inc;
  logic                 wrap;
  logic [SLOT_BITS-1:0] add_slot;
  logic                 add_ok;
  logic                 thr_we;
  logic                 sw;
  logic                 dir_ok;
  logic                 scan_hit;

  // Cursor advance, wrapping at the table length.
  assign cursor_inc = {1'b0, cursor_q} + LEN_BITS'(1);
  assign wrap       = (cursor_inc == len_q);

  // Match test for the slot under the cursor.
  always_comb begin
    case (req_q.req_type)
      REQ_ADD:  scan_hit = ~used_q[cursor_q];
      REQ_TICK: scan_hit = used_q[cursor_q] & ready_q[cursor_q];
      default:  scan_hit = 1'b1;
    endcase
  end

  // The scan ends once every slot below the length has been checked.
  assign status_o = '{scan_end: (count_q == len_q), hit: scan_hit};

  // Add goes to the free slot found, or appends one while there is room.
  assign add_slot = (cmd_i == CMD_HIT) ? cursor_q : len_q[SLOT_BITS-1:0];
  assign add_ok   = (cmd_i == CMD_HIT) || (len_q != LEN_BITS'(MAX_THREADS));

  // A tick switches unless it picked the slot already running.
  assign sw = ~(rvalid_q && (rslot_q == cursor_q));

  // Set status and remove need a used slot below the length.
  assign dir_ok = (({1'b0, req_q.slot_index}) < len_q) && used_q[req_q.slot_index];

  // Next state of the table and the scheduler.
  always_comb begin
    req_d    = req_q;
    cursor_d = cursor_q;
    count_d  = count_q;
    len_d    = len_q;
    nptr_d   = nptr_q;
    rslot_d  = rslot_q;
    rvalid_d = rvalid_q;
    used_d   = used_q;
    ready_d  = ready_q;
    out_d    = '0;
    done_d   = 1'b0;
    thr_we   = 1'b0;
    case (cmd_i)
      CMD_LOAD: begin
        req_d    = in_i;
        cursor_d = (in_i.req_type == REQ_TICK) ? nptr_q : '0;
        count_d  = '0;
      end
      CMD_STEP: begin
        cursor_d = wrap ? '0 : cursor_inc[SLOT_BITS-1:0];
        count_d  = count_q + LEN_BITS'(1);
      end
      CMD_HIT, CMD_MISS: begin
        done_d = 1'b1;
        case (req_q.req_type)
          REQ_ADD: begin
            if (add_ok) begin
              if (cmd_i == CMD_MISS) begin
                len_d = len_q + LEN_BITS'(1);
              end
              thr_we            = 1'b1;
              used_d[add_slot]  = 1'b1;
              ready_d[add_slot] = req_q.runnable;
              out_d.ok          = 1'b1;
              out_d.slot        = add_slot;
            end
          end
          REQ_TICK: begin
            if (cmd_i == CMD_HIT) begin
              nptr_d = wrap ? '0 : cursor_inc[SLOT_BITS-1:0];
              if (sw && rvalid_q && used_q[rslot_q]) begin
                ready_d[rslot_q] = 1'b1;
              end
              rslot_d             = cursor_q;
              rvalid_d            = 1'b1;
              ready_d[cursor_q]   = 1'b1;
              out_d.ok            = 1'b1;
              out_d.slot          = cursor_q;
              out_d.chosen_thread = thread_q[cursor_q];
              out_d.switched      = sw;
            end
          end
          default: begin
            out_d.ok   = dir_ok;
            out_d.slot = req_q.slot_index;
            if (dir_ok) begin
              if (req_q.req_type == REQ_SET) begin
                ready_d[req_q.slot_index] = req_q.runnable;
              end else begin
                used_d[req_q.slot_index]  = 1'b0;
                ready_d[req_q.slot_index] = 1'b0;
                if (rvalid_q && (rslot_q == req_q.slot_index)) begin
                  rvalid_d = 1'b0;
                end
              end
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Control and status registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      count_q  <= '0;
      len_q    <= '0;
      nptr_q   <= '0;
      rslot_q  <= '0;
      rvalid_q <= 1'b0;
      used_q   <= '0;
      ready_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      count_q  <= count_d;
      len_q    <= len_d;
      nptr_q   <= nptr_d;
      rslot_q  <= rslot_d;
      rvalid_q <= rvalid_d;
      used_q   <= used_d;
      ready_q  <= ready_d;
      done_q   <= done_d;
    end
  end

  // Payload registers: latched request, result word and thread ids.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
    if (thr_we) begin
      thread_q[add_slot] <= req_q.thread_id;
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  // The running slot always holds a thread.
  a_running_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> used_q[rslot_q])
    else $error("running slot is not in use");

  // The table never grows past its size.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_BITS'(MAX_THREADS))
    else $error("table length out of range");

  // The rotating pointer stays inside the table.
  a_nptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == '0) || ({1'b0, nptr_q} < len_q))
    else $error("next pointer beyond table length");

  // A successful result names a slot inside the table.
  a_ok_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && out_q.ok) |-> ({1'b0, out_q.slot} < len_q))
    else $error("result slot beyond table length");

endmodule

### sv/rrtp_ctrl.sv
// Controller state machine that sequences the slot scan.
`timescale 1ns / 1ps

module rrtp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  rrtp_pkg::scan_status_t status_i,
  output rrtp_pkg::cmd_e         cmd_o,
  output logic                   busy_o
);
  import rrtp_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands: one slot is checked per scan cycle.
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    busy_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        busy_o = 1'b1;
        if (status_i.scan_end) begin
          cmd_o   = CMD_MISS;
          state_d = ST_IDLE;
        end else if (status_i.hit) begin
          cmd_o   = CMD_HIT;
          state_d = ST_IDLE;
        end else begin
          cmd_o = CMD_STEP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/round_robin_thread_picker_top.sv
// Top level of the round-robin thread picker.
// Usage: drive a request word on in_i and raise start_i; the word is taken
// at a rising edge where start_i is high and busy_o is low. Requests are
// add thread, timer tick, set slot status and remove slot.
// Every request gives exactly one result word on out_o, shown for one
// cycle with done_o high; the receiver cannot hold it off.
// Add and tick walk the slot table one slot per cycle through the scan
// cursor. busy_o is low again in the result cycle, so the next request
// may be taken there.
// Reset clears the table (no slots, nothing running, pointer at slot 0);
// stored thread ids are only read back from slots that an add wrote.
`timescale 1ns / 1ps

module round_robin_thread_picker_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rrtp_pkg::in_word_t  in_i,
  output logic                busy_o,
  output logic                done_o,
  output rrtp_pkg::out_word_t out_o
);
  import rrtp_pkg::*;

  cmd_e         cmd;
  scan_status_t status;

  // Sequencer.
  rrtp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Table and scheduler state.
  rrtp_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .in_i     (in_i),
    .status_o (status),
    .done_o   (done_o),
    .out_o    (out_o)
  );

endmodule

### verif/round_robin_thread_picker_top_test.sv
// Self-checking testbench for the round-robin thread picker: directed and random requests.
`timescale 1ns / 1ps

// Tracks the slot table, predicts each result word and checks the block against it.
class picker_checker;
  logic [rrtp_pkg::THREAD_ID_BITS-1:0] tid_tab [rrtp_pkg::MAX_THREADS];
  bit                                  used_tab [rrtp_pkg::MAX_THREADS];
  bit                                  ready_tab [rrtp_pkg::MAX_THREADS];
  int unsigned                         tab_len;
  int unsigned                         scan_ptr;
  int unsigned                         run_slot;
  bit                                  run_valid;
  rrtp_pkg::out_word_t                 awaited_results [$];
  int unsigned errors, checked;
  int unsigned n_add, n_full, n_tick, n_no_thread, n_switch, n_edit, n_bad_slot;

  function new();
    for (int k = 0; k < rrtp_pkg::MAX_THREADS; k++) begin
      tid_tab[k]   = '0;
      used_tab[k]  = 1'b0;
      ready_tab[k] = 1'b0;
    end
    tab_len   = 0;
    scan_ptr  = 0;
    run_slot  = 0;
    run_valid = 1'b0;
    errors    = 0;
    checked   = 0;
    n_add = 0; n_full = 0; n_tick = 0; n_no_thread = 0;
    n_switch = 0; n_edit = 0; n_bad_slot = 0;
  endfunction

  // Apply one request to the table copy and return the word it should produce.
  function rrtp_pkg::out_word_t predict_outcome(rrtp_pkg::in_word_t w);
    rrtp_pkg::out_word_t           r;
    logic [rrtp_pkg::SLOT_BITS-1:0] s;
    int unsigned                   c;
    bit                            found;
    bit                            sw;
    r     = '0;
    s     = '0;
    found = 1'b0;
    case (w.req_type)
      rrtp_pkg::REQ_ADD: begin
        n_add++;
        // Lowest free slot below the length, else append one.
        for (int k = 0; k < tab_len; k++) begin
          if (!found && !used_tab[k]) begin
            s     = k[rrtp_pkg::SLOT_BITS-1:0];
            found = 1'b1;
          end
        end
        if (!found && tab_len >= rrtp_pkg::MAX_THREADS) begin
          n_full++;
        end else begin
          if (!found) begin
            s = tab_len[rrtp_pkg::SLOT_BITS-1:0];
            tab_len++;
          end
          tid_tab[s]   = w.thread_id;
          used_tab[s]  = 1'b1;
          ready_tab[s] = w.runnable;
          r.ok         = 1'b1;
          r.slot       = s;
        end
      end
      rrtp_pkg::REQ_TICK: begin
        n_tick++;
        // Circular scan from the rotating pointer for a used, ready slot.
        for (int k = 0; k < tab_len; k++) begin
          c = (scan_ptr + k) % tab_len;
          if (!found && used_tab[c] && ready_tab[c]) begin
            s     = c[rrtp_pkg::SLOT_BITS-1:0];
            found = 1'b1;
          end
        end
        if (!found) begin
          n_no_thread++;
        end else begin
          scan_ptr = (s + 1) % tab_len;
          sw = !(run_valid && run_slot == s);
          // The slot that ran before goes back to ready on a switch.
          if (sw && run_valid && used_tab[run_slot]) ready_tab[run_slot] = 1'b1;
          if (sw) n_switch++;
          run_slot        = s;
          run_valid       = 1'b1;
          ready_tab[s]    = 1'b1;
          r.ok            = 1'b1;
          r.slot          = s;
          r.chosen_thread = tid_tab[s];
          r.switched      = sw;
        end
      end
      default: begin
        n_edit++;
        r.slot = w.slot_index;
        if (w.slot_index >= tab_len || !used_tab[w.slot_index]) begin
          n_bad_slot++;
        end else begin
          r.ok = 1'b1;
          if (w.req_type == rrtp_pkg::REQ_SET) begin
            ready_tab[w.slot_index] = w.runnable;
          end else begin
            used_tab[w.slot_index]  = 1'b0;
            ready_tab[w.slot_index] = 1'b0;
            if (run_valid && run_slot == w.slot_index) run_valid = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Record an accepted request word.
  function void note_request(rrtp_pkg::in_word_t w);
    awaited_results.push_back(predict_outcome(w));
  endfunction

  function void report_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, fname, exp_v, got_v);
    errors++;
  endfunction

  // Compare a result word with the oldest prediction, field by field.
  function void check_result(rrtp_pkg::out_word_t got);
    rrtp_pkg::out_word_t exp_w;
    if (awaited_results.size() == 0) begin
      $display("%0t: result with no request outstanding: ok=%0b slot=%0d thread=%0h sw=%0b",
               $time, got.ok, got.slot, got.chosen_thread, got.switched);
      errors++;
    end else begin
      exp_w = awaited_results.pop_front();
      checked++;
      if (got.ok !== exp_w.ok) report_field("ok", 32'(exp_w.ok), 32'(got.ok));
      if (got.slot !== exp_w.slot) report_field("slot", 32'(exp_w.slot), 32'(got.slot));
      if (got.chosen_thread !== exp_w.chosen_thread)
        report_field("chosen_thread", 32'(exp_w.chosen_thread), 32'(got.chosen_thread));
      if (got.switched !== exp_w.switched)
        report_field("switched", 32'(exp_w.switched), 32'(got.switched));
    end
  endfunction
endclass

module round_robin_thread_picker_top_test;
  import rrtp_pkg::*;

  localparam int STALL_LIMIT = 400;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  in_word_t  in_i    = '0;
  logic      busy_o;
  logic      done_o;
  out_word_t out_o;

  picker_checker sb = new();
  int unsigned   stall_cycles = 0;

  round_robin_thread_picker_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (in_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .out_o  (out_o)
  );

  always #5 clk_i = ~clk_i;

  // Check results first, then record a request taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(out_o);
      if (start_i && !busy_o) sb.note_request(in_i);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("** round_robin_thread_picker_top: FAILED **");
        $finish;
      end
    end
  end

  // Present one word until it is taken, then maybe leave a gap.
  task automatic send_request(input in_word_t w, input int idle_pct);
    int gap;
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(8, 1);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic issue(input req_e req, input logic [THREAD_ID_BITS-1:0] tid,
                       input logic [SLOT_BITS-1:0] idx, input logic run);
    in_word_t w;
    w.req_type   = req;
    w.thread_id  = tid;
    w.slot_index = idx;
    w.runnable   = run;
    send_request(w, 0);
  endtask

  // Hold off the sender until every predicted word has been seen.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (sb.awaited_results.size() != 0);
    @(posedge clk_i);
  endtask

  // Random request; slot indexes mostly land inside the current table.
  function automatic in_word_t random_request(input int add_w, input int tick_w,
                                              input int set_w, input int run_pct);
    in_word_t w;
    int       pick;
    pick = $urandom_range(99);
    if (pick < add_w) w.req_type = REQ_ADD;
    else if (pick < add_w + tick_w) w.req_type = REQ_TICK;
    else if (pick < add_w + tick_w + set_w) w.req_type = REQ_SET;
    else w.req_type = REQ_REMOVE;
    w.thread_id = THREAD_ID_BITS'($urandom_range((1 << THREAD_ID_BITS) - 1));
    if (sb.tab_len > 0 && $urandom_range(9) < 8) begin
      w.slot_index = SLOT_BITS'($urandom_range(sb.tab_len - 1));
    end else begin
      w.slot_index = SLOT_BITS'($urandom_range(MAX_THREADS - 1));
    end
    w.runnable = ($urandom_range(99) < run_pct);
    return w;
  endfunction

  task automatic run_phase(input int idle_pct, input int add_w, input int tick_w,
                           input int set_w, input int run_pct, input int count);
    for (int n = 0; n < count; n++) begin
      send_request(random_request(add_w, tick_w, set_w, run_pct), idle_pct);
      if ($urandom_range(99) < 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, slot edits, switching rules, reuse and a full table.
    issue(REQ_TICK, 8'h00, 4'd0, 1'b0);
    issue(REQ_REMOVE, 8'h00, 4'd15, 1'b0);
    issue(REQ_ADD, 8'h00, 4'd0, 1'b1);
    issue(REQ_ADD, 8'hFF, 4'd15, 1'b0);
    issue(REQ_TICK, 8'h00, 4'd0, 1'b0);
    issue(REQ_TICK, 8'h00, 4'd0, 1'b0);
    issue(REQ_SET, 8'h00, 4'd1, 1'b1);
    issue(REQ_TICK, 8'h00, 4'd0, 1'b0);
    // The running slot is made not runnable; it returns to ready at the next switch.
    issue(REQ_SET, 8'h00, 4'd1, 1'b0);
    issue(REQ_TICK, 8'h00, 4'd0, 1'b0);
    issue(REQ_REMOVE, 8'h00, 4'd0, 1'b0);
    issue(REQ_TICK, 8'h00, 4'd0, 1'b0);
    issue(REQ_ADD, 8'hA5, 4'd0, 1'b1);
    issue(REQ_REMOVE, 8'h00, 4'd1, 1'b0);
    issue(REQ_SET, 8'h00, 4'd1, 1'b1);
    issue(REQ_SET, 8'h00, 4'd9, 1'b1);
    // Table not empty but nothing eligible.
    issue(REQ_SET, 8'h00, 4'd0, 1'b0);
    issue(REQ_TICK, 8'h00, 4'd0, 1'b0);
    for (int k = 0; k < MAX_THREADS; k++) begin
      issue(REQ_ADD, 8'($urandom), 4'($urandom), 1'($urandom));
    end
    issue(REQ_TICK, 8'h00, 4'd0, 1'b0);
    drain_results();

    // Random phases with different idling and request mixes.
    run_phase(0, 30, 35, 20, 60, 205);
    run_phase(84, 15, 35, 25, 30, 205);
    run_phase(37, 45, 35, 15, 80, 205);
    run_phase(0, 30, 35, 20, 60, 205);

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d adds (%0d refused as full), %0d ticks (%0d with no thread, %0d switches).",
             sb.n_add, sb.n_full, sb.n_tick, sb.n_no_thread, sb.n_switch);
    $display("Covered %0d set/remove requests (%0d on bad slots); %0d result words checked.",
             sb.n_edit, sb.n_bad_slot, sb.checked);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("** round_robin_thread_picker_top: PASSED **");
    end else begin
      $display("** round_robin_thread_picker_top: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
sv/rrtp_pkg.sv
sv/rrtp_datapath.sv
sv/rrtp_ctrl.sv
sv/round_robin_thread_picker_top.sv
verif/round_robin_thread_picker_top_test.sv
